>>> hdl/sensorless_bldc_commutator_assert.svh
// ---------------------------------------------------------------------------
// sensorless bldc commutator assertion macros
// shared concurrent assertion forms, sampled on the rising clock edge and
// disabled while reset is low
// ---------------------------------------------------------------------------
`ifndef SENSORLESS_BLDC_COMMUTATOR_ASSERT_SVH
`define SENSORLESS_BLDC_COMMUTATOR_ASSERT_SVH

// same-cycle implication
`define SBC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/sbc_pkg.sv
// ---------------------------------------------------------------------------
// sbc_pkg
// types, register codes, reset values and commutation tables shared by the
// sensorless bldc commutator
// ---------------------------------------------------------------------------
`default_nettype none

package sbc_pkg;

    // default widths
    localparam int SAMPLE_BITS_DEF = 8;
    localparam int WAIT_BITS_DEF   = 10;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int THR_W      = 8;
    localparam int DUTY_W     = 8;
    localparam int PERIOD_W   = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_BEMF_THRESHOLD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATE_DIRECTION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_DUTY     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_PERIOD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HANDOVER_PERIOD  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_DECREMENT = 3'd5;

    // register reset values
    localparam logic [THR_W-1:0]    RST_BEMF_THRESHOLD   = 8'd128;
    localparam logic [1:0]          RST_ROTATE_DIRECTION = 2'd0;
    localparam logic [DUTY_W-1:0]   RST_STARTUP_DUTY     = 8'd30;
    localparam logic [PERIOD_W-1:0] RST_STARTUP_PERIOD   = 10'd200;
    localparam logic [PERIOD_W-1:0] RST_HANDOVER_PERIOD  = 10'd50;
    localparam logic [PERIOD_W-1:0] RST_PERIOD_DECREMENT = 10'd2;

    // rotation codes
    localparam logic [1:0] DIR_FWD  = 2'd0;
    localparam logic [1:0] DIR_REV  = 2'd1;
    localparam logic [1:0] DIR_STOP = 2'd2;

    localparam logic [DUTY_W-1:0] DUTY_FULL = 8'hff;
    localparam logic [2:0]        POS_LAST  = 3'd5;
    localparam logic [1:0]        CHAN_LAST = 2'd2;
    localparam int                NUM_PHASE = 3;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic {
        REQ_SAMPLE = 1'b0,
        REQ_STEP   = 1'b1
    } t_req_kind;

    // switch enables per commutation step
    function automatic logic [5:0] gate_for(input logic [2:0] pos);
        logic [5:0] g;
        case (pos)
            3'd0:    g = 6'b001001;
            3'd1:    g = 6'b100001;
            3'd2:    g = 6'b100100;
            3'd3:    g = 6'b000110;
            3'd4:    g = 6'b010010;
            3'd5:    g = 6'b011000;
            default: g = 6'b000000;
        endcase
        return g;
    endfunction

    // back-emf pattern expected per direction and step, all ones never matches
    function automatic logic [7:0] expect_for(input logic [1:0] dir, input logic [2:0] pos);
        logic [7:0] e;
        e = 8'hff;
        if (dir == DIR_FWD) begin
            case (pos)
                3'd0:    e = 8'd6;
                3'd1:    e = 8'd4;
                3'd2:    e = 8'd5;
                3'd3:    e = 8'd1;
                3'd4:    e = 8'd3;
                3'd5:    e = 8'd2;
                default: e = 8'hff;
            endcase
        end else if (dir == DIR_REV) begin
            case (pos)
                3'd0:    e = 8'd2;
                3'd1:    e = 8'd6;
                3'd2:    e = 8'd4;
                3'd3:    e = 8'd5;
                3'd4:    e = 8'd1;
                3'd5:    e = 8'd3;
                default: e = 8'hff;
            endcase
        end
        return e;
    endfunction

    // next commutation step for the direction, stop parks at step zero
    function automatic logic [2:0] advance(input logic [1:0] dir, input logic [2:0] pos);
        logic [2:0] p;
        if (dir == DIR_FWD) begin
            p = (pos >= POS_LAST) ? 3'd0 : pos + 3'd1;
        end else if (dir == DIR_REV) begin
            p = (pos == 3'd0 || pos > POS_LAST) ? POS_LAST : pos - 3'd1;
        end else begin
            p = 3'd0;
        end
        return p;
    endfunction

endpackage

`default_nettype wire

>>> hdl/sbc_req_if.sv
// ---------------------------------------------------------------------------
// sbc_req_if
// input channel: adc sample or open-loop startup step request
// ---------------------------------------------------------------------------
`default_nettype none

interface sbc_req_if #(
    parameter int SAMPLE_BITS = sbc_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic                   req_type;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output req_type, output sample, input ready);
    modport sink   (input valid, input req_type, input sample, output ready);
endinterface

`default_nettype wire

>>> hdl/sbc_cmd_if.sv
// ---------------------------------------------------------------------------
// sbc_cmd_if
// classified command word from the front queue to the back end
// ---------------------------------------------------------------------------
`default_nettype none

interface sbc_cmd_if #(
    parameter int SAMPLE_BITS = sbc_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    sbc_pkg::t_req_kind     kind;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output kind, output sample, input ready);
    modport sink   (input valid, input kind, input sample, output ready);
endinterface

`default_nettype wire

>>> hdl/sbc_rsp_if.sv
// ---------------------------------------------------------------------------
// sbc_rsp_if
// result channel: gate enables, duty and commutation status
// ---------------------------------------------------------------------------
`default_nettype none

interface sbc_rsp_if #(
    parameter int WAIT_BITS = sbc_pkg::WAIT_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [5:0]           gate_pattern;
    logic [7:0]           duty;
    logic [2:0]           position;
    logic                 closed_loop;
    logic [1:0]           next_channel;
    logic [WAIT_BITS-1:0] step_wait;

    modport source (output valid, output gate_pattern, output duty, output position,
                    output closed_loop, output next_channel, output step_wait,
                    input ready);
    modport sink   (input valid, input gate_pattern, input duty, input position,
                    input closed_loop, input next_channel, input step_wait,
                    output ready);
endinterface

`default_nettype wire

>>> hdl/sbc_front.sv
// ---------------------------------------------------------------------------
// sbc_front
// accepts request words, classifies them and holds them in a two-word queue
// ---------------------------------------------------------------------------
`default_nettype none

`include "sensorless_bldc_commutator_assert.svh"

module sbc_front #(
    parameter int SAMPLE_BITS = sbc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sbc_req_if.sink    i_req,
    sbc_cmd_if.source  o_cmd
);
    localparam int PTR_W = $clog2(sbc_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(sbc_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(sbc_pkg::QUEUE_DEPTH);

    sbc_pkg::t_req_kind     r_kind [sbc_pkg::QUEUE_DEPTH];
    logic [SAMPLE_BITS-1:0] r_samp [sbc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]       r_wptr, n_wptr;
    logic [PTR_W-1:0]       r_rptr, n_rptr;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   push, pop;
    sbc_pkg::t_req_kind     kind;

    // classify the incoming word
    assign kind = i_req.req_type ? sbc_pkg::REQ_STEP : sbc_pkg::REQ_SAMPLE;

    // handshakes
    assign i_req.ready  = (r_cnt != FULL);
    assign push         = i_req.valid && i_req.ready;
    assign o_cmd.valid  = (r_cnt != '0);
    assign pop          = o_cmd.valid && o_cmd.ready;
    assign o_cmd.kind   = r_kind[r_rptr];
    assign o_cmd.sample = r_samp[r_rptr];

    // pointer and fill count
    always_comb begin
        n_wptr = push ? r_wptr + PTR_W'(1) : r_wptr;
        n_rptr = pop  ? r_rptr + PTR_W'(1) : r_rptr;
        n_cnt  = r_cnt + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_kind[r_wptr] <= kind;
            r_samp[r_wptr] <= i_req.sample;
        end
    end

    `SBC_ASSERT_IMPLY(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= FULL, "queue count overflow")
    `SBC_ASSERT_NEXT(a_cnt_track, i_clk, i_rst_n, push && !pop, r_cnt == $past(r_cnt) + CNT_W'(1), "queue count lost a push")

endmodule

`default_nettype wire

>>> hdl/sbc_back.sv
// ---------------------------------------------------------------------------
// sbc_back
// commutation state, configuration registers and result register
// ---------------------------------------------------------------------------
`default_nettype none

`include "sensorless_bldc_commutator_assert.svh"

module sbc_back #(
    parameter int SAMPLE_BITS = sbc_pkg::SAMPLE_BITS_DEF,
    parameter int WAIT_BITS   = sbc_pkg::WAIT_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [sbc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [sbc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    sbc_cmd_if.sink                             i_cmd,
    sbc_rsp_if.source                           o_rsp
);
    // compare widths cover both operands
    localparam int TW = (SAMPLE_BITS > sbc_pkg::THR_W) ? SAMPLE_BITS : sbc_pkg::THR_W;
    localparam int CW = (WAIT_BITS > sbc_pkg::PERIOD_W) ? WAIT_BITS : sbc_pkg::PERIOD_W;

    // configuration registers
    logic [sbc_pkg::THR_W-1:0]    r_thr;
    logic [1:0]                   r_dir;
    logic [sbc_pkg::DUTY_W-1:0]   r_sduty;
    logic [sbc_pkg::PERIOD_W-1:0] r_hover;
    logic [sbc_pkg::PERIOD_W-1:0] r_pdec;

    // commutation state
    logic [1:0]                   r_chan, n_chan;
    logic [SAMPLE_BITS-1:0]       r_samp [sbc_pkg::NUM_PHASE];
    logic [SAMPLE_BITS-1:0]       n_samp [sbc_pkg::NUM_PHASE];
    logic [2:0]                   r_pos, n_pos;
    logic                         r_closed, n_closed;
    logic                         r_speed, n_speed;
    logic [sbc_pkg::DUTY_W-1:0]   r_duty, n_duty;
    logic [WAIT_BITS-1:0]         r_wait, n_wait;

    // result register
    logic                         r_ovalid;
    logic [5:0]                   r_o_gate;
    logic [sbc_pkg::DUTY_W-1:0]   r_o_duty;
    logic [2:0]                   r_o_pos;
    logic                         r_o_closed;
    logic [1:0]                   r_o_chan;
    logic [WAIT_BITS-1:0]         r_o_wait;

    logic                         take;
    logic                         stalled;
    logic [2:0]                   pattern;
    logic [sbc_pkg::DUTY_W:0]     duty_inc;
    logic [CW-1:0]                wait_ext, dec_ext, hover_ext, diff;
    logic [CW-1:0]                cfg_ext;
    logic [WAIT_BITS-1:0]         reset_wait;

    assign i_cmd.ready = !r_ovalid || o_rsp.ready;
    assign take        = i_cmd.valid && i_cmd.ready;
    assign stalled     = r_ovalid && !o_rsp.ready;

    assign wait_ext   = CW'(r_wait);
    assign dec_ext    = CW'(r_pdec);
    assign hover_ext  = CW'(r_hover);
    assign diff       = wait_ext - dec_ext;
    assign duty_inc   = {1'b0, r_duty} + 9'd1;
    assign cfg_ext    = CW'(i_cfg_data);
    assign reset_wait = WAIT_BITS'(CW'(sbc_pkg::RST_STARTUP_PERIOD));

    // next commutation state
    always_comb begin
        n_chan   = r_chan;
        n_pos    = r_pos;
        n_closed = r_closed;
        n_speed  = r_speed;
        n_duty   = r_duty;
        n_wait   = r_wait;
        for (int k = 0; k < sbc_pkg::NUM_PHASE; k++) begin
            n_samp[k] = r_samp[k];
        end
        pattern = '0;

        if (take && i_cmd.kind == sbc_pkg::REQ_SAMPLE) begin
            // fill the phase slot, then check back-emf once the w slot is in
            for (int k = 0; k < sbc_pkg::NUM_PHASE; k++) begin
                if (r_chan == 2'(k)) begin
                    n_samp[k] = i_cmd.sample;
                end
            end
            n_chan = (r_chan >= sbc_pkg::CHAN_LAST) ? 2'd0 : r_chan + 2'd1;
            for (int k = 0; k < sbc_pkg::NUM_PHASE; k++) begin
                pattern[k] = (TW'(n_samp[k]) > TW'(r_thr));
            end
            if (n_chan == 2'd0 && r_dir < sbc_pkg::DIR_STOP && r_speed &&
                sbc_pkg::expect_for(r_dir, r_pos) == 8'(pattern)) begin
                n_pos    = sbc_pkg::advance(r_dir, r_pos);
                n_closed = 1'b1;
                n_duty   = sbc_pkg::DUTY_FULL;
                n_wait   = '0;
            end
        end else if (take && i_cmd.kind == sbc_pkg::REQ_STEP) begin
            if (r_dir >= sbc_pkg::DIR_STOP) begin
                // stop parks the rotor with duty off
                n_pos  = 3'd0;
                n_duty = '0;
            end else if (!r_closed) begin
                // open-loop ramp
                n_duty = (duty_inc < {1'b0, r_sduty}) ? duty_inc[sbc_pkg::DUTY_W-1:0] : r_sduty;
                if (wait_ext >= dec_ext && diff > hover_ext) begin
                    n_wait = diff[WAIT_BITS-1:0];
                end else begin
                    n_wait = hover_ext[WAIT_BITS-1:0];
                end
                if (n_wait == hover_ext[WAIT_BITS-1:0]) begin
                    n_speed = 1'b1;
                end
                n_pos = sbc_pkg::advance(r_dir, r_pos);
            end
        end

        // a new startup period reloads the wait while open loop
        if (i_cfg_we && i_cfg_index == sbc_pkg::CFG_STARTUP_PERIOD && !r_closed) begin
            n_wait = cfg_ext[WAIT_BITS-1:0];
        end
    end

    // configuration write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= sbc_pkg::RST_BEMF_THRESHOLD;
            r_dir     <= sbc_pkg::RST_ROTATE_DIRECTION;
            r_sduty   <= sbc_pkg::RST_STARTUP_DUTY;
            r_hover   <= sbc_pkg::RST_HANDOVER_PERIOD;
            r_pdec    <= sbc_pkg::RST_PERIOD_DECREMENT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sbc_pkg::CFG_BEMF_THRESHOLD:   r_thr     <= i_cfg_data[sbc_pkg::THR_W-1:0];
                sbc_pkg::CFG_ROTATE_DIRECTION: r_dir     <= i_cfg_data[1:0];
                sbc_pkg::CFG_STARTUP_DUTY:     r_sduty   <= i_cfg_data[sbc_pkg::DUTY_W-1:0];
                // startup period only reloads the wait count
                sbc_pkg::CFG_STARTUP_PERIOD:   ;
                sbc_pkg::CFG_HANDOVER_PERIOD:  r_hover   <= i_cfg_data;
                sbc_pkg::CFG_PERIOD_DECREMENT: r_pdec    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan   <= '0;
            r_pos    <= '0;
            r_closed <= 1'b0;
            r_speed  <= 1'b0;
            r_duty   <= '0;
            r_wait   <= reset_wait;
            for (int k = 0; k < sbc_pkg::NUM_PHASE; k++) begin
                r_samp[k] <= '0;
            end
        end else begin
            r_chan   <= n_chan;
            r_pos    <= n_pos;
            r_closed <= n_closed;
            r_speed  <= n_speed;
            r_duty   <= n_duty;
            r_wait   <= n_wait;
            for (int k = 0; k < sbc_pkg::NUM_PHASE; k++) begin
                r_samp[k] <= n_samp[k];
            end
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (take) begin
            r_ovalid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_o_gate   <= sbc_pkg::gate_for(n_pos);
            r_o_duty   <= n_duty;
            r_o_pos    <= n_pos;
            r_o_closed <= n_closed;
            r_o_chan   <= n_chan;
            r_o_wait   <= n_wait;
        end
    end

    assign o_rsp.valid        = r_ovalid;
    assign o_rsp.gate_pattern = r_o_gate;
    assign o_rsp.duty         = r_o_duty;
    assign o_rsp.position     = r_o_pos;
    assign o_rsp.closed_loop  = r_o_closed;
    assign o_rsp.next_channel = r_o_chan;
    assign o_rsp.step_wait    = r_o_wait;

    `SBC_ASSERT_IMPLY(a_pos_range, i_clk, i_rst_n, 1'b1, r_pos <= sbc_pkg::POS_LAST, "bad position")
    `SBC_ASSERT_NEXT(a_closed_sticky, i_clk, i_rst_n, r_closed, r_closed, "closed loop dropped")
    `SBC_ASSERT_IMPLY(a_no_overwrite, i_clk, i_rst_n, stalled, !take, "result word overwritten")

endmodule

`default_nettype wire

>>> hdl/sensorless_bldc_commutator.sv
// ---------------------------------------------------------------------------
// sensorless_bldc_commutator
// six-step sensorless bldc commutation with open-loop startup ramp
// ---------------------------------------------------------------------------
// Takes one request word per clock while the front queue has room and
// returns one result word for each via that queue and the result register.
// A two-word queue in front of the commutation logic and a result register
// behind it let input and output stall independently; all state updates for
// one word are made together when the back end takes it, so the sustained
// rate is one word per cycle unless the result side stalls. Configuration
// writes are taken on any cycle with i_cfg_we high and must be issued only
// while no word is in flight. No clearing pass is needed after reset.
`default_nettype none

module sensorless_bldc_commutator #(
    parameter int SAMPLE_BITS = sbc_pkg::SAMPLE_BITS_DEF,
    parameter int WAIT_BITS   = sbc_pkg::WAIT_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [sbc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [sbc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    sbc_req_if.sink                             i_req,
    sbc_rsp_if.source                           o_rsp
);
    // classified command words between front and back
    sbc_cmd_if #(.SAMPLE_BITS(SAMPLE_BITS)) cmd ();

    sbc_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_cmd   (cmd)
    );

    sbc_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .WAIT_BITS   (WAIT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire
